/* sv/dst_pkg.sv */
// Shared types, constants and reset values for the conveyor diameter sort tracker.
package dst_pkg;

    localparam int SLOTS_DEF   = 32;
    localparam int OUTLETS_DEF = 5;
    localparam int MAX_OUTLETS = 5;

    localparam int DIAM_W   = 16;
    localparam int SLOT_W   = 8;
    localparam int OUTLET_W = 3;
    localparam int POS_W    = 8 * MAX_OUTLETS;

    localparam logic [DIAM_W-1:0] THR_ONE_RST   = 16'd1500;
    localparam logic [DIAM_W-1:0] THR_TWO_RST   = 16'd1200;
    localparam logic [DIAM_W-1:0] THR_THREE_RST = 16'd900;
    localparam logic [DIAM_W-1:0] THR_FOUR_RST  = 16'd600;
    localparam logic [POS_W-1:0]  POSITIONS_RST = 40'h19_140F_0A05;

    // event kinds carried on tuser
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_CHECK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // register indexes, byte address 8*i
    localparam logic [2:0] REG_THR_ONE   = 3'd0;
    localparam logic [2:0] REG_THR_TWO   = 3'd1;
    localparam logic [2:0] REG_THR_THREE = 3'd2;
    localparam logic [2:0] REG_THR_FOUR  = 3'd3;
    localparam logic [2:0] REG_POSITIONS = 3'd4;

    localparam logic [OUTLET_W-1:0] OUTLET_NONE = 3'd0;

    typedef struct packed {
        logic shift;
        logic clear;
    } dst_cell_ctl_t;

    typedef struct packed {
        logic [DIAM_W-1:0] thr_one;
        logic [DIAM_W-1:0] thr_two;
        logic [DIAM_W-1:0] thr_three;
        logic [DIAM_W-1:0] thr_four;
        logic [POS_W-1:0]  positions;
    } dst_cfg_t;

    typedef struct packed {
        logic              hit;
        logic [DIAM_W-1:0] diameter;
        logic [SLOT_W-1:0] slot;
    } dst_probe_t;

endpackage

/* sv/dst_cell.sv */
// One carriage slot: diameter and valid mark, shifted in from the previous slot.
module dst_cell
    import dst_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dst_cell_ctl_t     ctl,
    input  logic [DIAM_W-1:0] prev_diameter,
    input  logic              prev_valid,
    output logic [DIAM_W-1:0] diameter,
    output logic              valid
);

    logic [DIAM_W-1:0] diameter_reg, diameter_next;
    logic              valid_reg, valid_next;

    always_comb begin
        diameter_next = diameter_reg;
        valid_next    = valid_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.shift) begin
            diameter_next = prev_diameter;
            valid_next    = prev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        diameter_reg <= diameter_next;
    end

    assign diameter = diameter_reg;
    assign valid    = valid_reg;

endmodule

/* sv/dst_match.sv */
// Classify a probed diameter and match it against the outlet positions; registered result.
module dst_match
    import dst_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int OUTLETS = OUTLETS_DEF
) (
    input  logic                aclk,
    input  logic                load,
    input  dst_cfg_t            cfg,
    input  dst_probe_t          probe,
    output logic [OUTLET_W-1:0] open_outlet
);

    localparam logic [SLOT_W:0] SLOTS_LIM = (SLOT_W+1)'(SLOTS);

    logic [OUTLET_W-1:0] cls;
    logic [SLOT_W:0]     pos;
    logic                found;
    logic [OUTLET_W-1:0] open_outlet_reg, open_outlet_next;

    always_comb begin
        if (probe.diameter > cfg.thr_one) begin
            cls = 3'd1;
        end else if (probe.diameter > cfg.thr_two) begin
            cls = 3'd2;
        end else if (probe.diameter > cfg.thr_three) begin
            cls = 3'd3;
        end else if (probe.diameter > cfg.thr_four) begin
            cls = 3'd4;
        end else begin
            cls = 3'd5;
        end
    end

    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int i = 0; i < OUTLETS; i++) begin
            pos = {1'b0, cfg.positions[8*i +: 8]};
            // fall back to the default spacing when the packed position is off the belt
            if (pos >= SLOTS_LIM) begin
                pos = (SLOT_W+1)'(5 + 5 * i);
            end
            if (pos < SLOTS_LIM && pos == {1'b0, probe.slot} && cls == OUTLET_W'(i + 1)) begin
                found = 1'b1;
            end
        end
        open_outlet_next = (probe.hit && found) ? cls : OUTLET_NONE;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            open_outlet_reg <= open_outlet_next;
        end
    end

    assign open_outlet = open_outlet_reg;

endmodule

/* sv/conveyor_diameter_sort_tracker.sv */
// The slot row and the probe register update when an input item is accepted;
// classification and outlet match then fill the output register (probe, output).
// Throughput: one item per cycle while the result channel is not stalled by m_tready.
// Reset (aresetn low, synchronous): every slot empty, thresholds 1500/1200/900/600,
// outlet positions 5/10/15/20/25, no result pending. Slot diameters are not reset.
module conveyor_diameter_sort_tracker
    import dst_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int OUTLETS = OUTLETS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] diameter, [23:16] slot_index
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] open_outlet, [7:3] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int              IDX_W     = $clog2(SLOTS);
    localparam logic [SLOT_W:0] SLOTS_LIM = (SLOT_W+1)'(SLOTS);

    // configuration registers
    dst_cfg_t   cfg_reg, cfg_next;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                REG_THR_ONE:   cfg_next.thr_one   = pwdata[DIAM_W-1:0];
                REG_THR_TWO:   cfg_next.thr_two   = pwdata[DIAM_W-1:0];
                REG_THR_THREE: cfg_next.thr_three = pwdata[DIAM_W-1:0];
                REG_THR_FOUR:  cfg_next.thr_four  = pwdata[DIAM_W-1:0];
                REG_POSITIONS: cfg_next.positions = pwdata[POS_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_THR_ONE:   prdata = {48'd0, cfg_reg.thr_one};
            REG_THR_TWO:   prdata = {48'd0, cfg_reg.thr_two};
            REG_THR_THREE: prdata = {48'd0, cfg_reg.thr_three};
            REG_THR_FOUR:  prdata = {48'd0, cfg_reg.thr_four};
            REG_POSITIONS: prdata = {24'd0, cfg_reg.positions};
            default:       prdata = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.thr_one   <= THR_ONE_RST;
            cfg_reg.thr_two   <= THR_TWO_RST;
            cfg_reg.thr_three <= THR_THREE_RST;
            cfg_reg.thr_four  <= THR_FOUR_RST;
            cfg_reg.positions <= POSITIONS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // handshake
    logic st_valid_reg, st_valid_next;
    logic m_valid_reg, m_valid_next;
    logic out_adv, st_adv, in_acc;

    assign out_adv  = !m_valid_reg || m_tready;
    assign st_adv   = st_valid_reg && out_adv;
    assign s_tready = !st_valid_reg || out_adv;
    assign in_acc   = s_tvalid && s_tready;

    logic [1:0]        in_kind;
    logic [DIAM_W-1:0] in_diameter;
    logic [SLOT_W-1:0] in_slot;

    assign in_kind     = s_tuser;
    assign in_diameter = s_tdata[15:0];
    assign in_slot     = s_tdata[23:16];

    // slot row
    dst_cell_ctl_t     cell_ctl;
    logic [DIAM_W-1:0] cell_diameter [SLOTS];
    logic              cell_valid    [SLOTS];

    assign cell_ctl.shift = in_acc && (in_kind == KIND_INSERT);
    assign cell_ctl.clear = in_acc && (in_kind == KIND_CLEAR);

    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        if (g == 0) begin : g_head
            dst_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .ctl           (cell_ctl),
                .prev_diameter (in_diameter),
                .prev_valid    (1'b1),
                .diameter      (cell_diameter[g]),
                .valid         (cell_valid[g])
            );
        end else begin : g_body
            dst_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .ctl           (cell_ctl),
                .prev_diameter (cell_diameter[g-1]),
                .prev_valid    (cell_valid[g-1]),
                .diameter      (cell_diameter[g]),
                .valid         (cell_valid[g])
            );
        end
    end

    // probe stage: pick the checked slot at accept time
    logic [IDX_W-1:0] slot_idx;
    logic             slot_in_range;
    dst_probe_t       probe_reg, probe_next;

    assign slot_idx      = in_slot[IDX_W-1:0];
    assign slot_in_range = {1'b0, in_slot} < SLOTS_LIM;

    always_comb begin
        probe_next = probe_reg;
        if (in_acc) begin
            probe_next.slot     = in_slot;
            probe_next.diameter = cell_diameter[slot_idx];
            probe_next.hit      = (in_kind == KIND_CHECK) && slot_in_range
                                  && cell_valid[slot_idx];
        end
    end

    always_ff @(posedge aclk) begin
        probe_reg <= probe_next;
    end

    always_comb begin
        st_valid_next = st_valid_reg;
        if (in_acc) begin
            st_valid_next = 1'b1;
        end else if (st_adv) begin
            st_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_adv) begin
            m_valid_next = st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    logic [OUTLET_W-1:0] open_outlet;

    dst_match #(
        .SLOTS   (SLOTS),
        .OUTLETS (OUTLETS)
    ) u_match (
        .aclk        (aclk),
        .load        (st_adv),
        .cfg         (cfg_reg),
        .probe       (probe_reg),
        .open_outlet (open_outlet)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, open_outlet};

endmodule
